FILE: sv/ssc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helpers for the SMTP session command block.
// No dependencies; compiled first.
package ssc_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned CODE_W  = 10;
  localparam int unsigned KIND_W  = 5;
  localparam int unsigned STATE_W = 3;

  // Session states, one-hot
  typedef enum logic [5:0] {
    ST_CONNECT    = 6'b000001,
    ST_HELLO      = 6'b000010,
    ST_SENDER     = 6'b000100,
    ST_RECIPIENT  = 6'b001000,
    ST_LETTER     = 6'b010000,
    ST_DISCONNECT = 6'b100000
  } session_t;

  // Encoded state numbers as seen on the result beat
  localparam logic [STATE_W-1:0] SNUM_CONNECT    = 3'd0;
  localparam logic [STATE_W-1:0] SNUM_HELLO      = 3'd1;
  localparam logic [STATE_W-1:0] SNUM_SENDER     = 3'd2;
  localparam logic [STATE_W-1:0] SNUM_RECIPIENT  = 3'd3;
  localparam logic [STATE_W-1:0] SNUM_LETTER     = 3'd4;
  localparam logic [STATE_W-1:0] SNUM_DISCONNECT = 3'd5;

  typedef enum logic [3:0] {
    VERB_HELO = 4'd0,
    VERB_EHLO = 4'd1,
    VERB_MAIL = 4'd2,
    VERB_RCPT = 4'd3,
    VERB_DATA = 4'd4,
    VERB_RSET = 4'd5,
    VERB_VRFY = 4'd6,
    VERB_EXPN = 4'd7,
    VERB_HELP = 4'd8,
    VERB_NOOP = 4'd9,
    VERB_QUIT = 4'd10,
    VERB_NONE = 4'd11
  } verb_t;

  localparam logic [LEN_W-1:0] VERB_LEN = 8'd4;

  // Lower-case verb spellings, first character in the top byte
  localparam logic [WORD_W-1:0] WORD_HELO = "helo";
  localparam logic [WORD_W-1:0] WORD_EHLO = "ehlo";
  localparam logic [WORD_W-1:0] WORD_MAIL = "mail";
  localparam logic [WORD_W-1:0] WORD_RCPT = "rcpt";
  localparam logic [WORD_W-1:0] WORD_DATA = "data";
  localparam logic [WORD_W-1:0] WORD_RSET = "rset";
  localparam logic [WORD_W-1:0] WORD_VRFY = "vrfy";
  localparam logic [WORD_W-1:0] WORD_EXPN = "expn";
  localparam logic [WORD_W-1:0] WORD_HELP = "help";
  localparam logic [WORD_W-1:0] WORD_NOOP = "noop";
  localparam logic [WORD_W-1:0] WORD_QUIT = "quit";

  // Reply message indices
  localparam logic [KIND_W-1:0] KIND_UNRECOGNISED = 5'd0;
  localparam logic [KIND_W-1:0] KIND_EHLO_GREET   = 5'd1;
  localparam logic [KIND_W-1:0] KIND_HELO_GREET   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_DUP_HELLO    = 5'd3;
  localparam logic [KIND_W-1:0] KIND_HELO_FIRST   = 5'd4;
  localparam logic [KIND_W-1:0] KIND_SENDER_OK    = 5'd5;
  localparam logic [KIND_W-1:0] KIND_SENDER_DUP   = 5'd6;
  localparam logic [KIND_W-1:0] KIND_RCPT_NO_MAIL = 5'd7;
  localparam logic [KIND_W-1:0] KIND_RCPT_OK      = 5'd8;
  localparam logic [KIND_W-1:0] KIND_DATA_NO_MAIL = 5'd9;
  localparam logic [KIND_W-1:0] KIND_DATA_NO_RCPT = 5'd10;
  localparam logic [KIND_W-1:0] KIND_ENTER_MAIL   = 5'd11;
  localparam logic [KIND_W-1:0] KIND_RESET        = 5'd12;
  localparam logic [KIND_W-1:0] KIND_NOT_IMPL     = 5'd13;
  localparam logic [KIND_W-1:0] KIND_HELP         = 5'd14;
  localparam logic [KIND_W-1:0] KIND_OK           = 5'd15;
  localparam logic [KIND_W-1:0] KIND_CLOSING      = 5'd16;

  localparam logic [CODE_W-1:0] CODE_HELP      = 10'd214;
  localparam logic [CODE_W-1:0] CODE_CLOSING   = 10'd221;
  localparam logic [CODE_W-1:0] CODE_OK        = 10'd250;
  localparam logic [CODE_W-1:0] CODE_START     = 10'd354;
  localparam logic [CODE_W-1:0] CODE_SYNTAX    = 10'd500;
  localparam logic [CODE_W-1:0] CODE_NOT_IMPL  = 10'd502;
  localparam logic [CODE_W-1:0] CODE_BAD_SEQ   = 10'd503;

  function automatic logic [CODE_W-1:0] kind_to_code(input logic [KIND_W-1:0] kind);
    logic [CODE_W-1:0] code;
    case (kind)
      KIND_EHLO_GREET, KIND_HELO_GREET, KIND_SENDER_OK, KIND_RCPT_OK,
      KIND_RESET, KIND_OK:                       code = CODE_OK;
      KIND_DUP_HELLO, KIND_HELO_FIRST, KIND_SENDER_DUP, KIND_RCPT_NO_MAIL,
      KIND_DATA_NO_MAIL, KIND_DATA_NO_RCPT:      code = CODE_BAD_SEQ;
      KIND_ENTER_MAIL:                           code = CODE_START;
      KIND_NOT_IMPL:                             code = CODE_NOT_IMPL;
      KIND_HELP:                                 code = CODE_HELP;
      KIND_CLOSING:                              code = CODE_CLOSING;
      default:                                   code = CODE_SYNTAX;
    endcase
    return code;
  endfunction

  function automatic logic [STATE_W-1:0] state_num(input session_t st);
    logic [STATE_W-1:0] num;
    unique case (st)
      ST_CONNECT:    num = SNUM_CONNECT;
      ST_HELLO:      num = SNUM_HELLO;
      ST_SENDER:     num = SNUM_SENDER;
      ST_RECIPIENT:  num = SNUM_RECIPIENT;
      ST_LETTER:     num = SNUM_LETTER;
      ST_DISCONNECT: num = SNUM_DISCONNECT;
      default:       num = SNUM_CONNECT;
    endcase
    return num;
  endfunction

endpackage
`default_nettype wire

FILE: sv/ssc_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Command channel: one received line per beat, valid/ready handshake.
// Depends on ssc_pkg for field widths.
interface ssc_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [ssc_pkg::WORD_W-1:0]  verb_word;
  logic [ssc_pkg::LEN_W-1:0]   verb_length;
  logic                        line_is_dot;
  logic                        line_empty;

  modport source (output valid, verb_word, verb_length, line_is_dot, line_empty,
                  input ready);
  modport sink   (input valid, verb_word, verb_length, line_is_dot, line_empty,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/ssc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Response channel: one result per command beat, valid/ready handshake.
// Depends on ssc_pkg for field widths.
interface ssc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         reply_valid;
  logic [ssc_pkg::CODE_W-1:0]   reply_code;
  logic [ssc_pkg::KIND_W-1:0]   reply_kind;
  logic                         store_line;
  logic                         end_of_input;
  logic [ssc_pkg::STATE_W-1:0]  session_now;

  modport source (output valid, reply_valid, reply_code, reply_kind, store_line,
                  end_of_input, session_now, input ready);
  modport sink   (input valid, reply_valid, reply_code, reply_kind, store_line,
                  end_of_input, session_now, output ready);
endinterface
`default_nettype wire

FILE: sv/ssc_verb_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// Verb decoder: folds A-Z to lower case and matches the eleven four-letter verbs.
// Depends on ssc_pkg.
module ssc_verb_decode (
  input  wire logic [ssc_pkg::WORD_W-1:0] verb_word,
  input  wire logic [ssc_pkg::LEN_W-1:0]  verb_length,
  output ssc_pkg::verb_t                  verb
);
  import ssc_pkg::*;

  logic [WORD_W-1:0] folded;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [7:0] ch;
      ch = verb_word[8*i +: 8];
      if (ch >= "A" && ch <= "Z") begin
        ch = ch + 8'h20;
      end
      folded[8*i +: 8] = ch;
    end
  end

  always_comb begin
    verb = VERB_NONE;
    if (verb_length == VERB_LEN) begin
      unique case (folded)
        WORD_HELO: verb = VERB_HELO;
        WORD_EHLO: verb = VERB_EHLO;
        WORD_MAIL: verb = VERB_MAIL;
        WORD_RCPT: verb = VERB_RCPT;
        WORD_DATA: verb = VERB_DATA;
        WORD_RSET: verb = VERB_RSET;
        WORD_VRFY: verb = VERB_VRFY;
        WORD_EXPN: verb = VERB_EXPN;
        WORD_HELP: verb = VERB_HELP;
        WORD_NOOP: verb = VERB_NOOP;
        WORD_QUIT: verb = VERB_QUIT;
        default:   verb = VERB_NONE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/smtp_session_command_fsm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// SMTP session command state machine, top level.
// Depends on ssc_pkg, ssc_cmd_if, ssc_rsp_if and ssc_verb_decode.
//
// One received line enters per cmd beat and exactly one result leaves per rsp
// beat, in order. The line is decoded and the session state stepped in the
// cycle of acceptance; the result is registered and offered in the next cycle.
// A new line can be taken every cycle: cmd.ready is high whenever the output
// register is empty or its beat is being taken in the same cycle. Throughput
// is one line per clock, set by the single output register. An empty line
// flags end_of_input and leaves the state alone; in the letter state lines are
// flagged for storage until a lone dot returns the session to hello.
module smtp_session_command_fsm_core (
  input  wire logic clk,
  input  wire logic rst,
  ssc_cmd_if.sink   cmd,
  ssc_rsp_if.source rsp
);
  import ssc_pkg::*;

  session_t state;
  session_t state_next;
  verb_t    verb;

  // Output register
  logic                out_valid;
  logic                reply_valid;
  logic [CODE_W-1:0]   reply_code;
  logic [KIND_W-1:0]   reply_kind;
  logic                store_line;
  logic                end_of_input;
  logic [STATE_W-1:0]  session_now;

  // Next result
  logic                reply_valid_next;
  logic [KIND_W-1:0]   reply_kind_next;
  logic                store_line_next;
  logic                end_of_input_next;

  logic accept;

  assign cmd.ready = !out_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;

  ssc_verb_decode u_decode (
    .verb_word   (cmd.verb_word),
    .verb_length (cmd.verb_length),
    .verb        (verb)
  );

  // Session step for the beat on the cmd channel
  always_comb begin
    state_next        = state;
    reply_valid_next  = 1'b0;
    reply_kind_next   = KIND_UNRECOGNISED;
    store_line_next   = 1'b0;
    end_of_input_next = 1'b0;

    if (cmd.line_empty) begin
      end_of_input_next = 1'b1;
    end else if (state == ST_LETTER) begin
      if (cmd.line_is_dot) begin
        state_next = ST_HELLO;
      end else begin
        store_line_next = 1'b1;
      end
    end else begin
      reply_valid_next = 1'b1;
      unique case (verb)
        VERB_HELO, VERB_EHLO: begin
          if (state == ST_CONNECT) begin
            state_next      = ST_HELLO;
            reply_kind_next = (verb == VERB_EHLO) ? KIND_EHLO_GREET : KIND_HELO_GREET;
          end else begin
            reply_kind_next = KIND_DUP_HELLO;
          end
        end
        VERB_MAIL: begin
          unique case (state)
            ST_CONNECT: reply_kind_next = KIND_HELO_FIRST;
            ST_HELLO: begin
              state_next      = ST_SENDER;
              reply_kind_next = KIND_SENDER_OK;
            end
            ST_SENDER, ST_RECIPIENT: reply_kind_next = KIND_SENDER_DUP;
            default: reply_valid_next = 1'b0;
          endcase
        end
        VERB_RCPT: begin
          unique case (state)
            ST_CONNECT, ST_HELLO: reply_kind_next = KIND_RCPT_NO_MAIL;
            ST_SENDER, ST_RECIPIENT: begin
              state_next      = ST_RECIPIENT;
              reply_kind_next = KIND_RCPT_OK;
            end
            default: reply_valid_next = 1'b0;
          endcase
        end
        VERB_DATA: begin
          unique case (state)
            ST_CONNECT, ST_HELLO: reply_kind_next = KIND_DATA_NO_MAIL;
            ST_SENDER:            reply_kind_next = KIND_DATA_NO_RCPT;
            ST_RECIPIENT: begin
              state_next      = ST_LETTER;
              reply_kind_next = KIND_ENTER_MAIL;
            end
            default: reply_valid_next = 1'b0;
          endcase
        end
        VERB_RSET: begin
          if (state != ST_CONNECT) begin
            state_next = ST_HELLO;
          end
          reply_kind_next = KIND_RESET;
        end
        VERB_VRFY, VERB_EXPN: reply_kind_next = KIND_NOT_IMPL;
        VERB_HELP:            reply_kind_next = KIND_HELP;
        VERB_NOOP:            reply_kind_next = KIND_OK;
        VERB_QUIT: begin
          state_next      = ST_DISCONNECT;
          reply_kind_next = KIND_CLOSING;
        end
        default: reply_kind_next = KIND_UNRECOGNISED;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CONNECT;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; code and kind read zero when no reply goes out
  always_ff @(posedge clk) begin
    if (accept) begin
      reply_valid  <= reply_valid_next;
      reply_kind   <= reply_valid_next ? reply_kind_next : KIND_UNRECOGNISED;
      reply_code   <= reply_valid_next ? kind_to_code(reply_kind_next) : '0;
      store_line   <= store_line_next;
      end_of_input <= end_of_input_next;
      session_now  <= state_num(state_next);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.reply_valid  = reply_valid;
  assign rsp.reply_code   = reply_code;
  assign rsp.reply_kind   = reply_kind;
  assign rsp.store_line   = store_line;
  assign rsp.end_of_input = end_of_input;
  assign rsp.session_now  = session_now;

`ifndef SYNTHESIS
  // A held result must stall the command side
  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |-> !cmd.ready)
    else $error("cmd accepted while result held");

  // End of input leaves the session untouched and is flagged next cycle
  a_eoi_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.line_empty) |=> (out_valid && end_of_input && state == $past(state)))
    else $error("end of input changed session state");

  // Body storage and replies are mutually exclusive
  a_store_no_reply: assert property (@(posedge clk) disable iff (rst)
    (out_valid && store_line) |-> (!reply_valid && !end_of_input))
    else $error("stored line also replied");

  // No reply means zero code and kind
  a_no_reply_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reply_valid) |-> (reply_code == '0 && reply_kind == '0))
    else $error("reply fields set without reply");

  // Non-empty, non-dot lines in the letter state are always stored
  a_store_in_letter: assert property (@(posedge clk) disable iff (rst)
    (accept && !cmd.line_empty && state == ST_LETTER && !cmd.line_is_dot)
      |=> (store_line && session_now == SNUM_LETTER))
    else $error("letter line not stored");
`endif

endmodule
`default_nettype wire

FILE: tb/smtp_session_command_fsm_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for smtp_session_command_fsm_core: drives received lines,
// predicts every reply beat and checks it field by field.
// Depends on ssc_pkg, ssc_cmd_if, ssc_rsp_if and the block itself.
module smtp_session_command_fsm_core_tb;
  import ssc_pkg::*;

  localparam int STALL_CYCLES   = 48;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 1000; // cycles with no beat on either side
  localparam int DRAIN_CYCLES   = 4;    // spare cycles after the last reply beat

  // Expected result of one line
  typedef struct packed {
    logic                reply_valid;
    logic [CODE_W-1:0]   reply_code;
    logic [KIND_W-1:0]   reply_kind;
    logic                store_line;
    logic                end_of_input;
    logic [STATE_W-1:0]  session_now;
  } reply_t;

  // Spellings indexed by verb_t, and reply codes indexed by message kind
  localparam logic [WORD_W-1:0] VERB_SPELLING [11] = '{
    WORD_HELO, WORD_EHLO, WORD_MAIL, WORD_RCPT, WORD_DATA, WORD_RSET,
    WORD_VRFY, WORD_EXPN, WORD_HELP, WORD_NOOP, WORD_QUIT
  };
  localparam logic [CODE_W-1:0] CODE_BY_KIND [17] = '{
    CODE_SYNTAX, CODE_OK, CODE_OK, CODE_BAD_SEQ, CODE_BAD_SEQ, CODE_OK,
    CODE_BAD_SEQ, CODE_BAD_SEQ, CODE_OK, CODE_BAD_SEQ, CODE_BAD_SEQ,
    CODE_START, CODE_OK, CODE_NOT_IMPL, CODE_HELP, CODE_OK, CODE_CLOSING
  };

  logic clk = 1'b0;
  logic rst;

  ssc_cmd_if cmd_ch ();
  ssc_rsp_if rsp_ch ();

  smtp_session_command_fsm_core i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bench copy of the session state, stepped once per accepted line
  logic [STATE_W-1:0] session_model = SNUM_CONNECT;
  reply_t             pending_replies [$];
  int                 lines_sent   = 0;
  int                 mismatches   = 0;
  int                 cmd_idle_pct = 0;
  int                 rsp_idle_pct = 0;
  int                 hold_asked   = 0;
  int                 hold_served  = 0;
  int                 hold_left    = 0;
  int unsigned        quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Fold A-Z only; anything else (digits, '@', '[' ...) stays as given.
  // A verb matches only when its length is exactly four.
  function automatic verb_t decode_verb_word(input logic [WORD_W-1:0] word,
                                             input logic [LEN_W-1:0]  len);
    logic [WORD_W-1:0] folded;
    verb_t             verb;
    int                b;
    folded = word;
    verb   = VERB_NONE;
    for (b = 0; b < 4; b++)
      if (folded[8*b +: 8] >= 8'h41 && folded[8*b +: 8] <= 8'h5A)
        folded[8*b + 5] = 1'b1;
    if (len == VERB_LEN) begin
      case (folded)
        WORD_HELO: verb = VERB_HELO;
        WORD_EHLO: verb = VERB_EHLO;
        WORD_MAIL: verb = VERB_MAIL;
        WORD_RCPT: verb = VERB_RCPT;
        WORD_DATA: verb = VERB_DATA;
        WORD_RSET: verb = VERB_RSET;
        WORD_VRFY: verb = VERB_VRFY;
        WORD_EXPN: verb = VERB_EXPN;
        WORD_HELP: verb = VERB_HELP;
        WORD_NOOP: verb = VERB_NOOP;
        WORD_QUIT: verb = VERB_QUIT;
        default:   verb = VERB_NONE;
      endcase
    end
    return verb;
  endfunction

  // Steps session_model by one line and returns the reply beat it should cause
  function automatic reply_t step_session(input logic [WORD_W-1:0] word,
                                          input logic [LEN_W-1:0]  len,
                                          input logic              dot,
                                          input logic              empty);
    reply_t            r;
    logic              answers;
    logic [KIND_W-1:0] kind;
    verb_t             verb;
    r       = '0;
    answers = 1'b0;
    kind    = KIND_UNRECOGNISED;
    verb    = decode_verb_word(word, len);
    if (empty) begin
      // end of input wins over everything, dot included; state untouched
      r.end_of_input = 1'b1;
    end else if (session_model == SNUM_LETTER) begin
      if (dot) session_model = SNUM_HELLO;
      else     r.store_line  = 1'b1;
    end else begin
      answers = 1'b1;
      case (verb)
        VERB_HELO, VERB_EHLO: begin
          if (session_model == SNUM_CONNECT) begin
            session_model = SNUM_HELLO;
            kind = (verb == VERB_EHLO) ? KIND_EHLO_GREET : KIND_HELO_GREET;
          end else begin
            kind = KIND_DUP_HELLO;
          end
        end
        VERB_MAIL: begin
          if (session_model == SNUM_CONNECT) begin
            kind = KIND_HELO_FIRST;
          end else if (session_model == SNUM_HELLO) begin
            session_model = SNUM_SENDER;
            kind = KIND_SENDER_OK;
          end else if (session_model == SNUM_SENDER ||
                       session_model == SNUM_RECIPIENT) begin
            kind = KIND_SENDER_DUP;
          end else begin
            answers = 1'b0;   // silent after QUIT
          end
        end
        VERB_RCPT: begin
          if (session_model == SNUM_CONNECT || session_model == SNUM_HELLO) begin
            kind = KIND_RCPT_NO_MAIL;
          end else if (session_model == SNUM_SENDER ||
                       session_model == SNUM_RECIPIENT) begin
            session_model = SNUM_RECIPIENT;
            kind = KIND_RCPT_OK;
          end else begin
            answers = 1'b0;
          end
        end
        VERB_DATA: begin
          if (session_model == SNUM_CONNECT || session_model == SNUM_HELLO) begin
            kind = KIND_DATA_NO_MAIL;
          end else if (session_model == SNUM_SENDER) begin
            kind = KIND_DATA_NO_RCPT;
          end else if (session_model == SNUM_RECIPIENT) begin
            session_model = SNUM_LETTER;
            kind = KIND_ENTER_MAIL;
          end else begin
            answers = 1'b0;
          end
        end
        VERB_RSET: begin
          if (session_model != SNUM_CONNECT) session_model = SNUM_HELLO;
          kind = KIND_RESET;
        end
        VERB_VRFY, VERB_EXPN: kind = KIND_NOT_IMPL;
        VERB_HELP:            kind = KIND_HELP;
        VERB_NOOP:            kind = KIND_OK;
        VERB_QUIT: begin
          session_model = SNUM_DISCONNECT;
          kind = KIND_CLOSING;
        end
        default:              kind = KIND_UNRECOGNISED;
      endcase
    end
    if (answers) begin
      r.reply_valid = 1'b1;
      r.reply_kind  = kind;
      r.reply_code  = CODE_BY_KIND[kind];
    end
    r.session_now = session_model;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Line source
  // ---------------------------------------------------------------------------

  // Offers one line, with random idle cycles first; valid stays high after the
  // beat so back-to-back lines need no extra edge.
  task automatic send_line(input logic [WORD_W-1:0] word,
                           input logic [LEN_W-1:0]  len,
                           input logic              dot,
                           input logic              empty);
    while ($urandom_range(0, 99) < cmd_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.verb_word   <= word;
    cmd_ch.verb_length <= len;
    cmd_ch.line_is_dot <= dot;
    cmd_ch.line_empty  <= empty;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    pending_replies.push_back(step_session(word, len, dot, empty));
    lines_sent++;
  endtask

  // Flips letters to upper case at random
  function automatic logic [WORD_W-1:0] scramble_case(input logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] mixed;
    int                b;
    mixed = word;
    for (b = 0; b < 4; b++)
      if (mixed[8*b +: 8] >= 8'h61 && mixed[8*b +: 8] <= 8'h7A && $urandom_range(0, 1))
        mixed[8*b + 5] = 1'b0;
    return mixed;
  endfunction

  task automatic send_verb(input verb_t verb);
    send_line(scramble_case(VERB_SPELLING[verb]), VERB_LEN, 1'b0, 1'b0);
  endtask

  task automatic send_body_line();
    send_line($urandom, 8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 9) == 0);
  endtask

  // Junk: raw lines, wrong-length verbs, verbs with one byte damaged, plain verbs
  task automatic send_noise();
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
    word = scramble_case(VERB_SPELLING[$urandom_range(0, 10)]);
    case ($urandom_range(0, 3))
      0: send_line($urandom, 8'($urandom_range(0, 255)), $urandom_range(0, 1),
                   $urandom_range(0, 7) == 0);
      1: begin
        len = 8'($urandom_range(0, 255));
        if (len == VERB_LEN) len = 8'd5;
        send_line(word, len, 1'b0, 1'b0);
      end
      2: begin
        word[8*$urandom_range(0, 3) +: 8] ^= 8'($urandom_range(1, 255));
        send_line(word, VERB_LEN, $urandom_range(0, 1), 1'b0);
      end
      default: send_line(word, VERB_LEN, $urandom_range(0, 1), 1'b0);
    endcase
  endtask

  // MAIL, RCPT..., DATA, body, dot - with the odd greeting, reset or junk
  task automatic run_mail_transaction();
    if (session_model == SNUM_DISCONNECT || $urandom_range(0, 4) == 0)
      send_verb(VERB_RSET);
    if ($urandom_range(0, 3) == 0)
      send_verb($urandom_range(0, 1) ? VERB_HELO : VERB_EHLO);
    send_verb(VERB_MAIL);
    repeat ($urandom_range(1, 3)) begin
      send_verb(VERB_RCPT);
      if ($urandom_range(0, 9) == 0) send_noise();
    end
    send_verb(VERB_DATA);
    repeat ($urandom_range(0, 6)) send_body_line();
    send_line($urandom, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served  <= hold_asked;
      hold_left    <= STALL_CYCLES - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: reply beat with nothing expected, expected none, got code %0d",
                 $time, rsp_ch.reply_code);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        compare_field("reply_valid",  want.reply_valid,  rsp_ch.reply_valid);
        compare_field("reply_code",   want.reply_code,   rsp_ch.reply_code);
        compare_field("reply_kind",   want.reply_kind,   rsp_ch.reply_kind);
        compare_field("store_line",   want.store_line,   rsp_ch.store_line);
        compare_field("end_of_input", want.end_of_input, rsp_ch.end_of_input);
        compare_field("session_now",  want.session_now,  rsp_ch.session_now);
      end
    end
  end

  // Watchdog: too long without a beat on either channel ends the run
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Connect through letter and back to hello. Connect is left for good after
  // the greeting, so HELO or EHLO greets at random and a second HELO gets the
  // duplicate reply; seeds between them cover both greetings.
  task automatic test_session_opening();
    logic greet_ehlo;
    greet_ehlo = $urandom_range(0, 1);
    send_line(32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1);  // end of input beats the dot
    send_line("mail", VERB_LEN, 1'b0, 1'b0);       // say hello first
    send_line("RCPT", VERB_LEN, 1'b0, 1'b0);       // need MAIL
    send_line("rset", VERB_LEN, 1'b0, 1'b0);       // reset, stays in connect
    send_line("help", 8'd0, 1'b0, 1'b0);           // zero length: unrecognised
    send_line("HELO", 8'd255, 1'b0, 1'b0);         // wrong length
    send_line("[elp", VERB_LEN, 1'b0, 1'b0);       // '[' is not folded
    send_line(greet_ehlo ? "EhLo" : "helo", VERB_LEN, 1'b0, 1'b0);
    send_line("helo", VERB_LEN, 1'b1, 1'b0);       // duplicate; dot ignored here
    send_line("data", VERB_LEN, 1'b0, 1'b0);       // need MAIL
    send_line("MaIl", VERB_LEN, 1'b0, 1'b0);
    send_line("data", VERB_LEN, 1'b0, 1'b0);       // need RCPT
    send_line("mail", VERB_LEN, 1'b0, 1'b0);       // sender already given
    send_line("rcpt", VERB_LEN, 1'b0, 1'b0);
    send_line("DATA", VERB_LEN, 1'b0, 1'b0);       // into letter
    send_line(32'h0, 8'd0, 1'b0, 1'b0);            // body line
    send_line(32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1);  // end of input in letter
    send_line(32'hFFFF_FFFF, 8'd255, 1'b1, 1'b0);  // lone dot, back to hello
  endtask

  // Odd verbs, QUIT, the silent verbs after it, and RSET out of disconnect
  task automatic test_session_close();
    send_line("vrfy", VERB_LEN, 1'b0, 1'b0);
    send_line("EXPN", VERB_LEN, 1'b0, 1'b0);
    send_line("Noop", VERB_LEN, 1'b0, 1'b0);
    send_line("help", VERB_LEN, 1'b0, 1'b0);
    send_line("QUIT", VERB_LEN, 1'b0, 1'b0);
    send_line("mail", VERB_LEN, 1'b0, 1'b0);
    send_line("rcpt", VERB_LEN, 1'b0, 1'b0);
    send_line("data", VERB_LEN, 1'b0, 1'b0);
    send_line("ehlo", VERB_LEN, 1'b0, 1'b0);       // duplicate even here
    send_line("rset", VERB_LEN, 1'b0, 1'b0);       // back to hello
  endtask

  // Mostly whole mail transactions, the rest junk, QUIT runs and verb soup
  task automatic test_random_traffic(input int cmd_pct, input int rsp_pct,
                                     input int line_count);
    int target;
    int pick;
    cmd_idle_pct = cmd_pct;
    rsp_idle_pct = rsp_pct;
    target       = lines_sent + line_count;
    while (lines_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        run_mail_transaction();
      end else if (pick < 85) begin
        send_noise();
      end else if (pick < 93) begin
        send_verb(VERB_QUIT);
        repeat ($urandom_range(0, 3)) send_verb(verb_t'($urandom_range(0, 10)));
      end else begin
        repeat ($urandom_range(2, 4)) send_verb(verb_t'($urandom_range(0, 10)));
      end
    end
  endtask

  // Receiver holds off for a long stretch while lines keep coming, so the
  // output register fills and cmd.ready must drop
  task automatic test_output_stall();
    cmd_idle_pct = 0;
    rsp_idle_pct = 0;
    hold_asked  <= hold_asked + 1;
    repeat (24) send_verb(verb_t'($urandom_range(0, 10)));
  endtask

  initial begin
    rst                = 1'b1;
    cmd_ch.valid       = 1'b0;
    cmd_ch.verb_word   = '0;
    cmd_ch.verb_length = '0;
    cmd_ch.line_is_dot = 1'b0;
    cmd_ch.line_empty  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    cmd_idle_pct = 14;
    rsp_idle_pct = 70;
    test_session_opening();
    test_session_close();
    test_random_traffic(14, 70, 250);
    test_random_traffic(70, 14, 250);
    test_random_traffic(0, 0, 250);
    test_output_stall();

    cmd_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
sv/ssc_pkg.sv
sv/ssc_cmd_if.sv
sv/ssc_rsp_if.sv
sv/ssc_verb_decode.sv
sv/smtp_session_command_fsm_core.sv
tb/smtp_session_command_fsm_core_tb.sv
